[sv/ffpa_pkg.sv]
// Shared constants and types for the first-fit page extent allocator.
package ffpa_pkg;
  localparam int NodeSlots = 64;
  localparam int PageBits  = 36;
  localparam int IdxW      = $clog2(NodeSlots);
  localparam int LinkW     = IdxW + 1;
  localparam logic [LinkW-1:0] Nil = LinkW'(NodeSlots);
  localparam int NodeW     = 2 * PageBits + LinkW;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree  = 2'd1;
  localparam logic [1:0] OpMark  = 2'd2;
  localparam logic [1:0] OpNop   = 2'd3;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StIgnored = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef struct packed {
    logic [PageBits-1:0] start;
    logic [PageBits-1:0] size;
    logic [LinkW-1:0]    link;
  } node_t;
endpackage

[sv/ffpa_ram.sv]
// Generic RAM with one write port and one read port, with registered read data.
module ffpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/first_fit_page_extent_allocator.sv]
// First-fit page extent allocator: request sequencer over a linked node store.
// Usage: requests enter on the s_axis group, one word per request, and each
// request returns exactly one result word on the m_axis group.
// s_axis_tdata holds opcode, page_number and page_count; m_axis_tdata holds
// result_page and status. Allocate and mark walk the free-extent list from its
// head, each node in SRead (address), then SEval (registered node RAM data),
// and visit at most NodeSlots nodes; a free does not walk the list, and an
// ignored request goes straight to the result. One request is worked at a time:
// s_axis_tready is low from acceptance until the result moves into the output
// register. A stalled receiver holds that register; the next request is still
// taken and worked, and its result waits until the output register is free.
// Reset empties the list and spare list and zeroes the fresh-node count; the
// node RAM is not cleared, since a node is always written before it is used.
module first_fit_page_extent_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [37:2] page_number, [73:38] page_count, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [35:0] result_page, [37:36] status, [39:38] zero
  output logic [39:0] m_axis_tdata
);
  localparam int PB = ffpa_pkg::PageBits;
  localparam int LW = ffpa_pkg::LinkW;
  localparam int IW = ffpa_pkg::IdxW;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SEval = 3'd2;
  localparam logic [2:0] SUpd  = 3'd3;
  localparam logic [2:0] SUpd2 = 3'd4;
  localparam logic [2:0] SSpr  = 3'd5;
  localparam logic [2:0] SOut  = 3'd6;

  logic [2:0]    state;
  logic [1:0]    op;
  logic [PB-1:0] page, count;
  logic [LW-1:0] list_head, spare_head, fresh_fill;
  logic [LW-1:0] cur, prev;
  logic [LW:0]   steps;
  logic [PB-1:0] rpage;
  logic [1:0]    status;
  logic          out_valid;
  logic [PB-1:0] out_page;
  logic [1:0]    out_status;
  logic [LW-1:0] took;
  logic          exact_q;
  ffpa_pkg::node_t cur_node, prev_node;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  ffpa_pkg::node_t wdata, rdata;

  ffpa_ram #(.Width(ffpa_pkg::NodeW), .Depth(ffpa_pkg::NodeSlots)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Compare terms for the node just read.
  logic [PB:0] base_w, ext_end, req_end;
  logic        fits, contains, exact;
  logic        have_node;
  logic [LW-1:0] new_node;
  always_comb begin
    base_w   = {1'b0, rdata.start};
    ext_end  = base_w + {1'b0, rdata.size};
    req_end  = {1'b0, page} + {1'b0, count};
    fits     = rdata.size >= count;
    contains = ({1'b0, page} >= base_w) && (req_end <= ext_end);
    exact    = (op == ffpa_pkg::OpAlloc) ? (rdata.size == count)
                                         : (page == rdata.start && req_end == ext_end);
    have_node = (spare_head < ffpa_pkg::Nil) || (fresh_fill < ffpa_pkg::Nil);
    new_node  = (spare_head < ffpa_pkg::Nil) ? spare_head : fresh_fill;
  end

  assign s_axis_tready = (state == SIdle);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_status, out_page};

  // Read address: next node of the walk; during evaluation the spare head is
  // read so that its link is ready if a spare node gets taken.
  always_comb begin
    raddr = cur[IW-1:0];
    if (state == SEval) raddr = spare_head[IW-1:0];
  end

  // Single write port: one node write per cycle, driven by the sequencer.
  always_comb begin
    we    = 1'b0;
    waddr = cur[IW-1:0];
    wdata = cur_node;
    case (state)
      SUpd: begin
        we = 1'b1;
        if (op == ffpa_pkg::OpFree) begin
          waddr = took[IW-1:0];
          wdata = '{start: page, size: count, link: list_head};
        end else if (exact_q) begin
          // Unlinking into prev is done in SUpd2; here the node joins the spare list.
          wdata = '{start: cur_node.start, size: cur_node.size, link: spare_head};
        end else if (op == ffpa_pkg::OpAlloc) begin
          wdata = '{start: cur_node.start + count, size: cur_node.size - count,
                    link: (prev < ffpa_pkg::Nil) ? list_head : cur_node.link};
        end else begin
          waddr = took[IW-1:0];
          wdata = '{start: req_end[PB-1:0],
                    size: cur_node.start + cur_node.size - req_end[PB-1:0],
                    link: list_head};
        end
      end
      SUpd2: begin
        we = 1'b1;
        if (op == ffpa_pkg::OpMark && !exact_q) begin
          wdata = '{start: cur_node.start, size: page - cur_node.start,
                    link: cur_node.link};
        end else begin
          waddr = prev[IW-1:0];
          wdata = '{start: prev_node.start, size: prev_node.size, link: cur_node.link};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SIdle;
      out_valid  <= 1'b0;
      list_head  <= ffpa_pkg::Nil;
      spare_head <= ffpa_pkg::Nil;
      fresh_fill <= '0;
    end else begin
      // The output register loads when it is empty or being emptied.
      if (state == SOut && (!out_valid || m_axis_tready)) begin
        out_valid  <= 1'b1;
        out_page   <= rpage;
        out_status <= status;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        SIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op    <= s_axis_tdata[1:0];
            page  <= s_axis_tdata[2 +: PB];
            count <= s_axis_tdata[38 +: PB];
            rpage <= '0;
            cur   <= list_head;
            prev  <= ffpa_pkg::Nil;
            steps <= '0;
            if (s_axis_tdata[38 +: PB] == '0 || s_axis_tdata[1:0] == ffpa_pkg::OpNop ||
                (s_axis_tdata[1:0] != ffpa_pkg::OpAlloc && s_axis_tdata[2 +: PB] == '0)) begin
              status <= ffpa_pkg::StIgnored;
              state  <= SOut;
            end else if (s_axis_tdata[1:0] == ffpa_pkg::OpFree) begin
              state <= SEval;
            end else if (list_head < ffpa_pkg::Nil) begin
              state <= SRead;
            end else begin
              status <= ffpa_pkg::StNoFit;
              state  <= SOut;
            end
          end
        end
        SRead: state <= SEval;
        SEval: begin
          exact_q <= exact;
          if (op == ffpa_pkg::OpFree) begin
            if (!have_node) begin
              status <= ffpa_pkg::StFull;
              state  <= SOut;
            end else begin
              took   <= new_node;
              status <= ffpa_pkg::StDone;
              state  <= (spare_head < ffpa_pkg::Nil) ? SSpr : SUpd;
              if (spare_head >= ffpa_pkg::Nil) fresh_fill <= fresh_fill + 1'b1;
            end
          end else if ((op == ffpa_pkg::OpAlloc && fits) ||
                       (op == ffpa_pkg::OpMark && contains)) begin
            cur_node <= rdata;
            status   <= ffpa_pkg::StDone;
            if (op == ffpa_pkg::OpAlloc) rpage <= rdata.start;
            if (op == ffpa_pkg::OpMark && !exact) begin
              if (!have_node) begin
                status <= ffpa_pkg::StFull;
                state  <= SOut;
              end else begin
                took  <= new_node;
                state <= (spare_head < ffpa_pkg::Nil) ? SSpr : SUpd;
                if (spare_head >= ffpa_pkg::Nil) fresh_fill <= fresh_fill + 1'b1;
              end
            end else begin
              state <= SUpd;
            end
          end else begin
            prev      <= cur;
            prev_node <= rdata;
            cur       <= rdata.link;
            steps     <= steps + 1'b1;
            if (rdata.link < ffpa_pkg::Nil && steps + 1'b1 < (LW+1)'(ffpa_pkg::NodeSlots))
              state <= SRead;
            else begin
              status <= ffpa_pkg::StNoFit;
              state  <= SOut;
            end
          end
        end
        SSpr: begin
          // Registered read of the spare node gives the new spare head.
          spare_head <= rdata.link;
          state      <= SUpd;
        end
        SUpd: begin
          if (op == ffpa_pkg::OpFree) begin
            list_head <= took;
            state     <= SOut;
          end else if (exact_q) begin
            spare_head <= cur;
            if (prev < ffpa_pkg::Nil) state <= SUpd2;
            else begin
              list_head <= cur_node.link;
              state     <= SOut;
            end
          end else if (op == ffpa_pkg::OpAlloc) begin
            list_head <= cur;
            state     <= (prev < ffpa_pkg::Nil) ? SUpd2 : SOut;
          end else begin
            list_head <= took;
            state     <= SUpd2;
          end
        end
        SUpd2: state <= SOut;
        SOut: begin
          if (!out_valid || m_axis_tready) state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule
